@@ hw/rtl/nmns_pkg.sv @@
package nmns_pkg;

   localparam int MAX_ENTRIES = 1024;
   localparam int COORD_BITS  = 16;
   localparam int ID_BITS     = 32;
   localparam int IDX_BITS    = $clog2(MAX_ENTRIES);
   localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);
   localparam int DIST_BITS   = COORD_BITS + 2;

   typedef enum logic [1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_APPEND = 2'd1,
      FUNC_QUERY  = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [ID_BITS-1:0]           id;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic append;
      logic start;
      logic issue;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic issue_done;
      logic pipe_empty;
      logic out_full;
   } status_type;

   function automatic logic [COORD_BITS:0] abs_diff(
      input logic signed [COORD_BITS-1:0] a,
      input logic signed [COORD_BITS-1:0] b
   );
      logic signed [COORD_BITS:0] d;
      d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
      if (d[COORD_BITS]) begin
         return (COORD_BITS + 1)'(-d);
      end
      return d;
   endfunction

endpackage

@@ hw/rtl/nmns_if.sv @@
interface nmns_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [1:0]                              func;
   logic [nmns_pkg::ID_BITS-1:0]            entry_id;
   logic signed [nmns_pkg::COORD_BITS-1:0]  entry_x;
   logic signed [nmns_pkg::COORD_BITS-1:0]  entry_y;
   logic [nmns_pkg::ID_BITS-1:0]            query_id;
   logic signed [nmns_pkg::COORD_BITS-1:0]  query_x;
   logic signed [nmns_pkg::COORD_BITS-1:0]  query_y;

   modport source (
      output valid, func, entry_id, entry_x, entry_y, query_id, query_x, query_y,
      input  ready
   );
   modport sink (
      input  valid, func, entry_id, entry_x, entry_y, query_id, query_x, query_y,
      output ready
   );
endinterface

interface nmns_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    found;
   logic signed [nmns_pkg::COORD_BITS-1:0]  near_x;
   logic signed [nmns_pkg::COORD_BITS-1:0]  near_y;
   logic                                    table_overflow;

   modport source (
      output valid, found, near_x, near_y, table_overflow,
      input  ready
   );
   modport sink (
      input  valid, found, near_x, near_y, table_overflow,
      output ready
   );
endinterface

@@ hw/rtl/nmns_datapath.sv @@
module nmns_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  nmns_pkg::cmd_type                      cmd,
   output nmns_pkg::status_type                   status,
   input  logic [nmns_pkg::ID_BITS-1:0]           entry_id,
   input  logic signed [nmns_pkg::COORD_BITS-1:0] entry_x,
   input  logic signed [nmns_pkg::COORD_BITS-1:0] entry_y,
   input  logic [nmns_pkg::ID_BITS-1:0]           query_id,
   input  logic signed [nmns_pkg::COORD_BITS-1:0] query_x,
   input  logic signed [nmns_pkg::COORD_BITS-1:0] query_y,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_found,
   output logic signed [nmns_pkg::COORD_BITS-1:0] rsp_near_x,
   output logic signed [nmns_pkg::COORD_BITS-1:0] rsp_near_y,
   output logic                                   rsp_table_overflow
);

   nmns_pkg::entry_type mem [nmns_pkg::MAX_ENTRIES];

   logic [nmns_pkg::CNT_BITS-1:0]           count_ff, count_in;
   logic                                    ovf_ff, ovf_in;
   logic [nmns_pkg::CNT_BITS-1:0]           scan_ff, scan_in;
   logic [nmns_pkg::ID_BITS-1:0]            qid_ff;
   logic signed [nmns_pkg::COORD_BITS-1:0]  qx_ff;
   logic signed [nmns_pkg::COORD_BITS-1:0]  qy_ff;
   nmns_pkg::entry_type                     rd_ff;
   logic                                    rd_vld_ff, rd_vld_in;
   logic [nmns_pkg::DIST_BITS-1:0]          dist_ff;
   logic signed [nmns_pkg::COORD_BITS-1:0]  dx_ff;
   logic signed [nmns_pkg::COORD_BITS-1:0]  dy_ff;
   logic                                    d_vld_ff, d_vld_in;
   logic                                    have_ff, have_in;
   logic [nmns_pkg::DIST_BITS-1:0]          best_ff;
   logic signed [nmns_pkg::COORD_BITS-1:0]  bx_ff;
   logic signed [nmns_pkg::COORD_BITS-1:0]  by_ff;
   logic                                    out_vld_ff, out_vld_in;
   logic                                    full;
   logic                                    take;
   logic [nmns_pkg::COORD_BITS:0]           adx;
   logic [nmns_pkg::COORD_BITS:0]           ady;

   assign full = (count_ff == nmns_pkg::CNT_BITS'(nmns_pkg::MAX_ENTRIES));
   assign take = d_vld_ff && (!have_ff || (dist_ff < best_ff));
   assign adx  = nmns_pkg::abs_diff(rd_ff.x, qx_ff);
   assign ady  = nmns_pkg::abs_diff(rd_ff.y, qy_ff);

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (cmd.clear) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end else if (cmd.append) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_comb begin
      scan_in = scan_ff;
      if (cmd.start) begin
         scan_in = '0;
      end else if (cmd.issue) begin
         scan_in = scan_ff + 1'b1;
      end
   end

   assign rd_vld_in = cmd.issue;
   assign d_vld_in  = rd_vld_ff && (rd_ff.id != qid_ff);

   always_comb begin
      have_in = have_ff;
      if (cmd.start) begin
         have_in = 1'b0;
      end else if (take) begin
         have_in = 1'b1;
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      if (cmd.load_out) begin
         out_vld_in = 1'b1;
      end else if (rsp_valid && rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
         scan_ff    <= '0;
         rd_vld_ff  <= 1'b0;
         d_vld_ff   <= 1'b0;
         have_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         ovf_ff     <= ovf_in;
         scan_ff    <= scan_in;
         rd_vld_ff  <= rd_vld_in;
         d_vld_ff   <= d_vld_in;
         have_ff    <= have_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append && !full) begin
         mem[count_ff[nmns_pkg::IDX_BITS-1:0]] <= '{id: entry_id, x: entry_x, y: entry_y};
      end
      if (cmd.issue) begin
         rd_ff <= mem[scan_ff[nmns_pkg::IDX_BITS-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         qid_ff <= query_id;
         qx_ff  <= query_x;
         qy_ff  <= query_y;
      end
      dist_ff <= nmns_pkg::DIST_BITS'(adx) + nmns_pkg::DIST_BITS'(ady);
      dx_ff   <= rd_ff.x;
      dy_ff   <= rd_ff.y;
      if (cmd.start) begin
         bx_ff   <= '0;
         by_ff   <= '0;
         best_ff <= '0;
      end else if (take) begin
         bx_ff   <= dx_ff;
         by_ff   <= dy_ff;
         best_ff <= dist_ff;
      end
      if (cmd.load_out) begin
         rsp_found          <= have_ff;
         rsp_near_x         <= bx_ff;
         rsp_near_y         <= by_ff;
         rsp_table_overflow <= ovf_ff;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign status.issue_done = (scan_ff == count_ff);
   assign status.pipe_empty = !rd_vld_ff && !d_vld_ff;
   assign status.out_full   = out_vld_ff;

endmodule

@@ hw/rtl/nmns_ctrl.sv @@
module nmns_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_func,
   input  nmns_pkg::status_type status,
   output nmns_pkg::cmd_type    cmd
);

   nmns_pkg::state_type state_ff, state_in;
   nmns_pkg::func_type  func;
   logic                accept;

   assign func   = nmns_pkg::func_type'(req_func);
   assign accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nmns_pkg::ST_IDLE: begin
            if (accept && (func == nmns_pkg::FUNC_QUERY)) begin
               state_in = nmns_pkg::ST_SCAN;
            end
         end
         nmns_pkg::ST_SCAN: begin
            if (status.issue_done) begin
               state_in = nmns_pkg::ST_DRAIN;
            end
         end
         nmns_pkg::ST_DRAIN: begin
            if (status.pipe_empty) begin
               state_in = nmns_pkg::ST_FINISH;
            end
         end
         nmns_pkg::ST_FINISH: begin
            if (!status.out_full) begin
               state_in = nmns_pkg::ST_IDLE;
            end
         end
         default: state_in = nmns_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         nmns_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.clear  = accept && (func == nmns_pkg::FUNC_CLEAR);
            cmd.append = accept && (func == nmns_pkg::FUNC_APPEND);
            cmd.start  = accept && (func == nmns_pkg::FUNC_QUERY);
         end
         nmns_pkg::ST_SCAN: begin
            cmd.issue = !status.issue_done;
         end
         nmns_pkg::ST_DRAIN: begin
         end
         nmns_pkg::ST_FINISH: begin
            cmd.load_out = !status.out_full;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nmns_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/nearest_manhattan_neighbor_search_core.sv @@
// Nearest neighbor search by Manhattan distance over a table of up to 1024 entries.
// The request channel carries one item per transfer: func 0 clears the table and the
// sticky overflow flag, func 1 appends an entry (identifier, x, y), func 2 runs a query
// and func 3 is ignored. Only a query produces a transfer on the response channel.
// A query reads the entry memory once per cycle through its single read port. The
// request channel stays busy while the query scans the table, drains the pipeline and
// loads the result, and the next request can transfer in the cycle after the load.
// Entries whose identifier equals the query identifier are skipped; ties go to the
// entry that was loaded first. Appends to a full table are dropped and set the
// overflow flag that every query result reports.
// The response sits in an output register, so a clear or append can be taken while a
// result waits. A query that finishes while the previous result is still stalled
// holds in its final state until the receiver takes the earlier transfer.
// Reset empties the table, clears the overflow flag and drops any pending result;
// the entry memory itself is not cleared.
module nearest_manhattan_neighbor_search_core (
   input logic        clock,
   input logic        reset,
   nmns_req_if.sink   req_ch,
   nmns_rsp_if.source rsp_ch
);

   nmns_pkg::cmd_type    cmd;
   nmns_pkg::status_type status;

   nmns_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_func  (req_ch.func),
      .status    (status),
      .cmd       (cmd)
   );

   nmns_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .entry_id           (req_ch.entry_id),
      .entry_x            (req_ch.entry_x),
      .entry_y            (req_ch.entry_y),
      .query_id           (req_ch.query_id),
      .query_x            (req_ch.query_x),
      .query_y            (req_ch.query_y),
      .rsp_valid          (rsp_ch.valid),
      .rsp_ready          (rsp_ch.ready),
      .rsp_found          (rsp_ch.found),
      .rsp_near_x         (rsp_ch.near_x),
      .rsp_near_y         (rsp_ch.near_y),
      .rsp_table_overflow (rsp_ch.table_overflow)
   );

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !status.out_full)
      else $error("result loaded over a pending response");

   a_issue_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !status.issue_done)
      else $error("read issued beyond the stored entries");

   a_load_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.pipe_empty)
      else $error("result loaded while the scan pipeline is busy");

   a_query_blocks: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> !req_ch.ready)
      else $error("request taken while a query is running");

endmodule

@@ verif/tb_nearest_manhattan_neighbor_search_core.sv @@
module tb_nearest_manhattan_neighbor_search_core;

   localparam logic [1:0] FUNC_UNUSED  = 2'd3;
   localparam int         CYCLE_LIMIT  = 400000;
   localparam int         LONG_HOLD    = 400;
   localparam int         RANDOM_ITEMS = 580;
   localparam int         IDLE_PCT     = 21;

   typedef logic signed [nmns_pkg::COORD_BITS-1:0] coord_type;
   typedef logic [nmns_pkg::ID_BITS-1:0]           agent_id_type;

   localparam coord_type COORD_MIN = coord_type'(-32768);
   localparam coord_type COORD_MAX = coord_type'(32767);
   localparam coord_type COORD_M1  = coord_type'(-1);

   typedef struct {
      logic [1:0]   func;
      agent_id_type entry_id;
      coord_type    entry_x;
      coord_type    entry_y;
      agent_id_type query_id;
      coord_type    query_x;
      coord_type    query_y;
   } agent_cmd_type;

   typedef struct {
      logic      found;
      coord_type near_x;
      coord_type near_y;
      logic      table_overflow;
   } neighbor_type;

   typedef struct {
      agent_cmd_type cmd;
      bit            fixed;
      neighbor_type  fixed_rsp;
   } directed_row_type;

   logic clock;
   logic reset;

   nmns_req_if req_ch();
   nmns_rsp_if rsp_ch();

   nearest_manhattan_neighbor_search_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   nmns_pkg::entry_type agent_table [nmns_pkg::MAX_ENTRIES];
   int unsigned         agent_count;
   bit                  overflow_seen;
   neighbor_type        pending_neighbors [$];
   directed_row_type    directed_rows [$];
   int unsigned         fail_count = 0;
   int unsigned         cycle_count = 0;
   int unsigned         moved_items = 0;
   int unsigned         hold_requests = 0;
   bit                  no_idle = 1'b0;

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic int manhattan(nmns_pkg::entry_type e, coord_type qx, coord_type qy);
      int dx;
      int dy;
      dx = int'($signed(e.x)) - int'(qx);
      dy = int'($signed(e.y)) - int'(qy);
      if (dx < 0) begin
         dx = -dx;
      end
      if (dy < 0) begin
         dy = -dy;
      end
      return dx + dy;
   endfunction

   // Updates the table copy and returns 1 when the command yields a result.
   function automatic bit predict_cmd(agent_cmd_type c, output neighbor_type n);
      int best;
      int d;
      n.found          = 1'b0;
      n.near_x         = '0;
      n.near_y         = '0;
      n.table_overflow = 1'b0;
      best             = 0;
      case (c.func)
         nmns_pkg::FUNC_CLEAR: begin
            agent_count   = 0;
            overflow_seen = 1'b0;
         end
         nmns_pkg::FUNC_APPEND: begin
            if (agent_count < nmns_pkg::MAX_ENTRIES) begin
               agent_table[agent_count].id = c.entry_id;
               agent_table[agent_count].x  = c.entry_x;
               agent_table[agent_count].y  = c.entry_y;
               agent_count++;
            end else begin
               overflow_seen = 1'b1;
            end
         end
         nmns_pkg::FUNC_QUERY: begin
            for (int unsigned i = 0; i < agent_count; i++) begin
               if (agent_table[i].id != c.query_id) begin
                  d = manhattan(agent_table[i], c.query_x, c.query_y);
                  if (!n.found || d < best) begin
                     n.found  = 1'b1;
                     best     = d;
                     n.near_x = agent_table[i].x;
                     n.near_y = agent_table[i].y;
                  end
               end
            end
            n.table_overflow = overflow_seen;
            return 1'b1;
         end
         default: begin
         end
      endcase
      return 1'b0;
   endfunction

   function automatic neighbor_type make_rsp(logic found, coord_type x, coord_type y,
                                             logic ovf);
      neighbor_type r;
      r.found          = found;
      r.near_x         = x;
      r.near_y         = y;
      r.table_overflow = ovf;
      return r;
   endfunction

   function automatic agent_cmd_type make_cmd(logic [1:0] f, agent_id_type eid,
                                              coord_type ex, coord_type ey,
                                              agent_id_type qid, coord_type qx,
                                              coord_type qy);
      agent_cmd_type c;
      c.func     = f;
      c.entry_id = eid;
      c.entry_x  = ex;
      c.entry_y  = ey;
      c.query_id = qid;
      c.query_x  = qx;
      c.query_y  = qy;
      return c;
   endfunction

   function automatic coord_type rand_coord();
      return coord_type'($urandom);
   endfunction

   function automatic agent_cmd_type rand_cmd(logic [1:0] f);
      return make_cmd(f, $urandom, rand_coord(), rand_coord(), $urandom, rand_coord(),
                      rand_coord());
   endfunction

   function automatic coord_type pick_coord(int mode);
      case (mode)
         0: return rand_coord();
         1: return coord_type'(int'($urandom_range(8)) - 4);
         default: begin
            case ($urandom_range(4))
               0: return COORD_MIN;
               1: return COORD_MAX;
               2: return '0;
               3: return COORD_M1;
               default: return rand_coord();
            endcase
         end
      endcase
   endfunction

   task automatic add_row(agent_cmd_type c, bit fixed, neighbor_type r);
      directed_row_type row;
      row.cmd       = c;
      row.fixed     = fixed;
      row.fixed_rsp = r;
      directed_rows.push_back(row);
   endtask

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic issue_cmd(agent_cmd_type c, bit fixed, neighbor_type fixed_rsp);
      neighbor_type n;
      bit           has_rsp;
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.func     = c.func;
      req_ch.entry_id = c.entry_id;
      req_ch.entry_x  = c.entry_x;
      req_ch.entry_y  = c.entry_y;
      req_ch.query_id = c.query_id;
      req_ch.query_x  = c.query_x;
      req_ch.query_y  = c.query_y;
      req_ch.valid    = 1'b1;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      has_rsp = predict_cmd(c, n);
      if (has_rsp) begin
         pending_neighbors.push_back(fixed ? fixed_rsp : n);
      end
      if (c.func != FUNC_UNUSED) begin
         moved_items++;
      end
      @(negedge clock);
   endtask

   task automatic issue_query(agent_id_type qid, coord_type qx, coord_type qy,
                              neighbor_type none);
      agent_cmd_type c;
      c          = rand_cmd(nmns_pkg::FUNC_QUERY);
      c.query_id = qid;
      c.query_x  = qx;
      c.query_y  = qy;
      issue_cmd(c, 1'b0, none);
   endtask

   task automatic issue_append(agent_id_type eid, coord_type ex, coord_type ey,
                               neighbor_type none);
      agent_cmd_type c;
      c          = rand_cmd(nmns_pkg::FUNC_APPEND);
      c.entry_id = eid;
      c.entry_x  = ex;
      c.entry_y  = ey;
      issue_cmd(c, 1'b0, none);
   endtask

   always @(posedge clock) begin
      neighbor_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_neighbors.size() == 0) begin
            $error("unexpected result transfer: found %0d near_x %0d near_y %0d",
                   rsp_ch.found, rsp_ch.near_x, rsp_ch.near_y);
            fail_count++;
         end else begin
            want = pending_neighbors.pop_front();
            if (rsp_ch.found !== want.found) begin
               $error("found: expected %0d, actual %0d", want.found, rsp_ch.found);
               fail_count++;
            end
            if (rsp_ch.near_x !== want.near_x) begin
               $error("near_x: expected %0d, actual %0d", want.near_x, rsp_ch.near_x);
               fail_count++;
            end
            if (rsp_ch.near_y !== want.near_y) begin
               $error("near_y: expected %0d, actual %0d", want.near_y, rsp_ch.near_y);
               fail_count++;
            end
            if (rsp_ch.table_overflow !== want.table_overflow) begin
               $error("table_overflow: expected %0d, actual %0d",
                      want.table_overflow, rsp_ch.table_overflow);
               fail_count++;
            end
         end
      end
   end

   // The receiver stalls at random, and once for a long stretch on request.
   initial begin
      int unsigned hold_left;
      int unsigned hold_seen;
      hold_left    = 0;
      hold_seen    = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready = 1'b0;
            hold_left--;
         end else if (hold_seen != hold_requests) begin
            hold_seen    = hold_requests;
            hold_left    = LONG_HOLD - 1;
            rsp_ch.ready = 1'b0;
         end else begin
            rsp_ch.ready = no_idle || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb_nearest_manhattan_neighbor_search_core NOT OK");
      $finish;
   end

   initial begin
      neighbor_type  none;
      agent_cmd_type c;
      agent_id_type  id_base;
      int unsigned   random_start;
      int unsigned   episode;
      int            mode;
      int            n_entries;
      int            n_queries;
      int            r;

      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.func     = nmns_pkg::FUNC_CLEAR;
      req_ch.entry_id = '0;
      req_ch.entry_x  = '0;
      req_ch.entry_y  = '0;
      req_ch.query_id = '0;
      req_ch.query_x  = '0;
      req_ch.query_y  = '0;
      agent_count     = 0;
      overflow_seen   = 1'b0;
      none            = make_rsp(1'b0, '0, '0, 1'b0);

      add_row(make_cmd(nmns_pkg::FUNC_QUERY, 0, 0, 0, 32'h1234_5678, 0, 0), 1'b1, none);
      add_row(make_cmd(FUNC_UNUSED, '1, COORD_M1, COORD_M1, '1, COORD_M1, COORD_M1), 1'b0,
              none);
      add_row(make_cmd(nmns_pkg::FUNC_APPEND, 5, COORD_MIN, COORD_MIN, 0, 0, 0), 1'b0, none);
      add_row(make_cmd(nmns_pkg::FUNC_APPEND, 5, COORD_MAX, COORD_MAX, 0, 0, 0), 1'b0, none);
      add_row(make_cmd(nmns_pkg::FUNC_QUERY, 0, 0, 0, 5, 0, 0), 1'b1, none);
      add_row(make_cmd(nmns_pkg::FUNC_QUERY, 0, 0, 0, 6, 0, 0), 1'b0, none);
      add_row(make_cmd(nmns_pkg::FUNC_QUERY, 0, 0, 0, 0, COORD_MIN, COORD_MIN), 1'b1,
              make_rsp(1'b1, COORD_MIN, COORD_MIN, 1'b0));
      add_row(make_cmd(nmns_pkg::FUNC_QUERY, 0, 0, 0, '1, COORD_MAX, COORD_MIN), 1'b0, none);
      add_row(make_cmd(nmns_pkg::FUNC_APPEND, '1, 100, coord_type'(-100), 0, 0, 0), 1'b0,
              none);
      add_row(make_cmd(nmns_pkg::FUNC_QUERY, 0, 0, 0, '1, 100, coord_type'(-100)), 1'b0,
              none);
      add_row(make_cmd(nmns_pkg::FUNC_QUERY, 0, 0, 0, 5, 100, coord_type'(-100)), 1'b1,
              make_rsp(1'b1, 100, coord_type'(-100), 1'b0));
      add_row(make_cmd(nmns_pkg::FUNC_APPEND, 7, 0, 0, 0, 0, 0), 1'b0, none);
      add_row(make_cmd(nmns_pkg::FUNC_APPEND, 8, 0, 0, 0, 0, 0), 1'b0, none);
      add_row(make_cmd(nmns_pkg::FUNC_QUERY, 0, 0, 0, 9, 1, 1), 1'b0, none);
      add_row(make_cmd(nmns_pkg::FUNC_QUERY, 0, 0, 0, 7, 0, 0), 1'b0, none);
      add_row(make_cmd(nmns_pkg::FUNC_CLEAR, '1, COORD_M1, COORD_M1, '1, COORD_M1,
                       COORD_M1), 1'b0, none);
      add_row(make_cmd(nmns_pkg::FUNC_QUERY, 0, 0, 0, 9, 0, 0), 1'b1, none);
      add_row(make_cmd(nmns_pkg::FUNC_APPEND, 3, 1, 2, 0, 0, 0), 1'b0, none);
      add_row(make_cmd(nmns_pkg::FUNC_APPEND, 3, 5, 5, 0, 0, 0), 1'b0, none);
      add_row(make_cmd(nmns_pkg::FUNC_QUERY, 0, 0, 0, 3, 0, 0), 1'b1, none);
      add_row(make_cmd(nmns_pkg::FUNC_QUERY, 0, 0, 0, 4, COORD_M1, coord_type'(-2)), 1'b0,
              none);
      add_row(make_cmd(FUNC_UNUSED, 0, 0, 0, 0, 0, 0), 1'b0, none);
      add_row(make_cmd(nmns_pkg::FUNC_QUERY, 0, 0, 0, 4, COORD_MAX, COORD_MAX), 1'b0, none);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         issue_cmd(directed_rows[i].cmd, directed_rows[i].fixed, directed_rows[i].fixed_rsp);
      end

      // Fill the table to capacity, then push past it to set the sticky flag.
      issue_cmd(rand_cmd(nmns_pkg::FUNC_CLEAR), 1'b0, none);
      repeat (nmns_pkg::MAX_ENTRIES) begin
         issue_append($urandom, rand_coord(), rand_coord(), none);
      end
      issue_query($urandom, rand_coord(), rand_coord(), none);
      repeat (2) begin
         issue_append($urandom, rand_coord(), rand_coord(), none);
      end
      issue_query($urandom, rand_coord(), rand_coord(), none);
      issue_query(agent_table[0].id, agent_table[0].x, agent_table[0].y, none);
      issue_cmd(rand_cmd(nmns_pkg::FUNC_CLEAR), 1'b0, none);
      c = make_cmd(nmns_pkg::FUNC_QUERY, 0, 0, 0, $urandom, rand_coord(), rand_coord());
      issue_cmd(c, 1'b1, none);
      issue_append(11, COORD_MIN, COORD_MAX, none);
      issue_query(12, COORD_MAX, COORD_MIN, none);

      random_start = moved_items;
      episode      = 0;
      while (moved_items < random_start + RANDOM_ITEMS) begin
         episode++;
         no_idle = (moved_items >= random_start + 250) && (moved_items < random_start + 380);
         if (agent_count > 40 || $urandom_range(99) < 85) begin
            issue_cmd(rand_cmd(nmns_pkg::FUNC_CLEAR), 1'b0, none);
         end
         mode      = $urandom_range(2);
         id_base   = $urandom;
         n_entries = ($urandom_range(3) == 0) ? $urandom_range(13, 30) : $urandom_range(8);
         repeat (n_entries) begin
            issue_append(id_base + $urandom_range(5), pick_coord(mode), pick_coord(mode),
                         none);
         end
         if (episode == 15) begin
            // Long receiver stall while queries keep coming, so the block backs up.
            hold_requests++;
            repeat (6) begin
               issue_query(id_base + $urandom_range(5), pick_coord(mode), pick_coord(mode),
                           none);
            end
         end
         n_queries = $urandom_range(1, 4);
         repeat (n_queries) begin
            r = $urandom_range(99);
            if (r < 5) begin
               issue_cmd(rand_cmd(FUNC_UNUSED), 1'b0, none);
            end else if (r < 25) begin
               issue_append(id_base + $urandom_range(5), pick_coord(mode), pick_coord(mode),
                            none);
            end
            issue_query(($urandom_range(4) == 0) ? $urandom : id_base + $urandom_range(5),
                        pick_coord(mode), pick_coord(mode), none);
         end
         if (episode == 16 || $urandom_range(11) == 0) begin
            req_ch.valid = 1'b0;
            wait (pending_neighbors.size() == 0);
            @(negedge clock);
         end
      end
      no_idle = 1'b0;

      req_ch.valid = 1'b0;
      wait (pending_neighbors.size() == 0);
      repeat (nmns_pkg::MAX_ENTRIES + 16) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_nearest_manhattan_neighbor_search_core OK");
      end else begin
         $display("tb_nearest_manhattan_neighbor_search_core NOT OK");
      end
      $finish;
   end

endmodule
